// ===== sv/pts_pkg.sv =====
// Shared constants, types and sequencer state encoding for the priority tick scheduler.
package pts_pkg;

    localparam int NUM_TASKS = 4;
    localparam int TASK_W    = 2;
    localparam int PRIO_W    = 16;
    localparam int SLICE_W   = 18;
    localparam int OUT_SL_W  = 17;
    localparam int TICK_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [SLICE_W-1:0] SLICE_MIN  = -18'sd65536;
    localparam logic signed [SLICE_W-1:0] SLICE_ZERO = '0;
    localparam logic [TASK_W-1:0]         IDX_LAST   = TASK_W'(NUM_TASKS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_CHK,
        ST_SCAN,
        ST_RINIT,
        ST_RLD,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic              busy;
        logic              accept;
        logic              dec;
        logic              chk;
        logic              scan;
        logic              rinit;
        logic              rld;
        logic              fin;
        logic [TASK_W-1:0] idx;
    } ctrl_t;

    typedef struct packed {
        logic irq;
        logic gt;
        logic best_zero;
    } stat_t;

endpackage

// ===== sv/priority_tick_task_scheduler.sv =====
// Top level of the priority tick scheduler: task state, shared comparator and sequencer.
//
// One tick is taken when start is high and busy is low, and its result appears on
// done for exactly one cycle. A tick during an interrupt only decrements the running
// task's slice; else the task is kept while its slice is above zero, or the four slices
// are scanned and, when every slice is used up, all are reloaded. The sequencer visits
// one task per cycle through a single shared signed comparator. The receiver cannot
// stall a result, and results are held in output registers, so a new tick may start
// in the cycle that done is shown. Configuration writes are always ready and must only
// be issued while no tick is in progress; each write with an index below four also
// reloads that task's slice, and writes to other indexes are ignored.
module priority_tick_task_scheduler (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  in_interrupt,
    output logic                                  done,
    output logic [pts_pkg::TASK_W-1:0]            running_task,
    output logic signed [pts_pkg::OUT_SL_W-1:0]   slice_left,
    output logic [pts_pkg::TICK_W-1:0]            tick_total,
    output logic                                  switched,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pts_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pts_pkg::PRIO_W-1:0]            cfg_data
);

    pts_pkg::ctrl_t ctrl;
    pts_pkg::stat_t stat;

    logic [pts_pkg::PRIO_W-1:0]          prio_reg   [pts_pkg::NUM_TASKS];
    logic signed [pts_pkg::SLICE_W-1:0]  slices_reg [pts_pkg::NUM_TASKS];

    logic [pts_pkg::TASK_W-1:0]          cur_reg;
    logic [pts_pkg::TASK_W-1:0]          cur_next;
    logic [pts_pkg::TASK_W-1:0]          before_reg;
    logic                                irq_reg;
    logic [pts_pkg::TICK_W-1:0]          tick_reg;
    logic signed [pts_pkg::SLICE_W-1:0]  best_reg;
    logic signed [pts_pkg::SLICE_W-1:0]  best_next;

    logic                                done_reg;
    logic [pts_pkg::TASK_W-1:0]          task_out_reg;
    logic signed [pts_pkg::OUT_SL_W-1:0] slice_out_reg;
    logic [pts_pkg::TICK_W-1:0]          tick_out_reg;
    logic                                sw_out_reg;

    logic [pts_pkg::TASK_W-1:0]          slice_addr;
    logic [pts_pkg::TASK_W-1:0]          prio_addr;
    logic signed [pts_pkg::SLICE_W-1:0]  slice_rd;
    logic [pts_pkg::PRIO_W-1:0]          prio_rd;
    logic signed [pts_pkg::SLICE_W-1:0]  prio_rd_ext;
    logic                                gt;
    logic                                cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready &&
                       (cfg_index < pts_pkg::CFG_IDX_W'(pts_pkg::NUM_TASKS));

    pts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign slice_addr  = ctrl.scan ? ctrl.idx : cur_reg;
    assign prio_addr   = ctrl.rld ? ctrl.idx : cur_reg;
    assign slice_rd    = slices_reg[slice_addr];
    assign prio_rd     = prio_reg[prio_addr];
    assign prio_rd_ext = $signed({{(pts_pkg::SLICE_W - pts_pkg::PRIO_W){1'b0}}, prio_rd});

    pts_cmp u_cmp (
        .ctrl     (ctrl),
        .slice_rd (slice_rd),
        .prio_rd  (prio_rd),
        .best     (best_reg),
        .gt       (gt)
    );

    assign stat.irq       = irq_reg;
    assign stat.gt        = gt;
    assign stat.best_zero = (best_reg == pts_pkg::SLICE_ZERO) && !gt;

    always_comb
    begin
        cur_next  = cur_reg;
        best_next = best_reg;
        if (ctrl.chk)
        begin
            best_next = pts_pkg::SLICE_ZERO;
        end
        else if (ctrl.scan && gt)
        begin
            best_next = slice_rd;
            cur_next  = ctrl.idx;
        end
        else if (ctrl.rinit)
        begin
            best_next = prio_rd_ext;
        end
        else if (ctrl.rld && gt)
        begin
            best_next = prio_rd_ext;
            cur_next  = ctrl.idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pts_pkg::NUM_TASKS; i++)
            begin
                prio_reg[i]   <= '0;
                slices_reg[i] <= '0;
            end
            cur_reg    <= '0;
            before_reg <= '0;
            irq_reg    <= 1'b0;
            tick_reg   <= '0;
            best_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cur_reg  <= cur_next;
            best_reg <= best_next;
            done_reg <= ctrl.fin;
            if (ctrl.accept)
            begin
                before_reg <= cur_reg;
                irq_reg    <= in_interrupt;
                tick_reg   <= tick_reg + 1'b1;
            end
            if (cfg_we)
            begin
                prio_reg[cfg_index[pts_pkg::TASK_W-1:0]]   <= cfg_data;
                slices_reg[cfg_index[pts_pkg::TASK_W-1:0]] <=
                    $signed({{(pts_pkg::SLICE_W - pts_pkg::PRIO_W){1'b0}}, cfg_data});
            end
            else if (ctrl.dec && gt)
            begin
                slices_reg[cur_reg] <= slice_rd - 18'sd1;
            end
            else if (ctrl.rld)
            begin
                slices_reg[ctrl.idx] <= prio_rd_ext;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fin)
        begin
            task_out_reg  <= cur_reg;
            slice_out_reg <= slice_rd[pts_pkg::OUT_SL_W-1:0];
            tick_out_reg  <= tick_reg;
            sw_out_reg    <= (cur_reg != before_reg);
        end
    end

    assign busy         = ctrl.busy;
    assign done         = done_reg;
    assign running_task = task_out_reg;
    assign slice_left   = slice_out_reg;
    assign tick_total   = tick_out_reg;
    assign switched     = sw_out_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat shown while a tick is still in progress");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted tick did not make the block busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a tick in progress");

    a_irq_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.fin && irq_reg) |-> (cur_reg == before_reg))
        else $error("task changed on a tick taken during an interrupt");

endmodule

// ===== sv/pts_cmp.sv =====
// Shared signed comparator with operand selection for the decrement, check, scan and reload steps.
module pts_cmp (
    input  pts_pkg::ctrl_t                        ctrl,
    input  logic signed [pts_pkg::SLICE_W-1:0]    slice_rd,
    input  logic [pts_pkg::PRIO_W-1:0]            prio_rd,
    input  logic signed [pts_pkg::SLICE_W-1:0]    best,
    output logic                                  gt
);

    logic signed [pts_pkg::SLICE_W-1:0] op_a;
    logic signed [pts_pkg::SLICE_W-1:0] op_b;
    logic signed [pts_pkg::SLICE_W-1:0] prio_ext;

    assign prio_ext = $signed({{(pts_pkg::SLICE_W - pts_pkg::PRIO_W){1'b0}}, prio_rd});

    always_comb
    begin
        op_a = slice_rd;
        op_b = pts_pkg::SLICE_ZERO;
        if (ctrl.dec)
        begin
            op_b = pts_pkg::SLICE_MIN;
        end
        else if (ctrl.scan)
        begin
            op_b = best;
        end
        else if (ctrl.rld)
        begin
            op_a = prio_ext;
            op_b = best;
        end
    end

    assign gt = op_a > op_b;

endmodule

// ===== sv/pts_ctrl.sv =====
// Sequencer that steps one tick through decrement, check, scan and reload.
module pts_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  pts_pkg::stat_t  stat,
    output pts_pkg::ctrl_t  ctrl
);

    pts_pkg::state_t                state_reg;
    pts_pkg::state_t                state_next;
    logic [pts_pkg::TASK_W-1:0]     idx_reg;
    logic [pts_pkg::TASK_W-1:0]     idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pts_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            pts_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = pts_pkg::ST_DEC;
                end
            end
            pts_pkg::ST_DEC:
            begin
                state_next = stat.irq ? pts_pkg::ST_FIN : pts_pkg::ST_CHK;
            end
            pts_pkg::ST_CHK:
            begin
                idx_next   = '0;
                state_next = stat.gt ? pts_pkg::ST_FIN : pts_pkg::ST_SCAN;
            end
            pts_pkg::ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == pts_pkg::IDX_LAST)
                begin
                    state_next = stat.best_zero ? pts_pkg::ST_RINIT : pts_pkg::ST_FIN;
                end
            end
            pts_pkg::ST_RINIT:
            begin
                idx_next   = '0;
                state_next = pts_pkg::ST_RLD;
            end
            pts_pkg::ST_RLD:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == pts_pkg::IDX_LAST)
                begin
                    state_next = pts_pkg::ST_FIN;
                end
            end
            pts_pkg::ST_FIN:
            begin
                state_next = pts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl        = '0;
        ctrl.idx    = idx_reg;
        ctrl.busy   = (state_reg != pts_pkg::ST_IDLE);
        case (state_reg)
            pts_pkg::ST_IDLE:  ctrl.accept = start;
            pts_pkg::ST_DEC:   ctrl.dec    = 1'b1;
            pts_pkg::ST_CHK:   ctrl.chk    = 1'b1;
            pts_pkg::ST_SCAN:  ctrl.scan   = 1'b1;
            pts_pkg::ST_RINIT: ctrl.rinit  = 1'b1;
            pts_pkg::ST_RLD:   ctrl.rld    = 1'b1;
            pts_pkg::ST_FIN:   ctrl.fin    = 1'b1;
            default:           ctrl.busy   = 1'b1;
        endcase
    end

endmodule
